>>> hw/rtl/msadpcm_pkg.sv
// ----------------------------------------------------------------------------
// msadpcm_pkg - shared types and constants of the MS ADPCM block decoder
// Payload structs, command words between front and back, predictor tables.
// ----------------------------------------------------------------------------
package msadpcm_pkg;

    localparam int CHAN_W    = 2;
    localparam int ALIGN_W   = 14;
    localparam int SAMPLE_W  = 16;
    localparam int DELTA_W   = 16;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHAN_W-1:0]   CHAN_RESET  = 2'd1;
    localparam logic [ALIGN_W-1:0]  ALIGN_RESET = 14'd256;
    localparam logic [DELTA_W-1:0]  DELTA_RESET = 16'd16;
    localparam logic [DELTA_W-1:0]  DELTA_FLOOR = 16'd16;
    localparam logic [IDX_W-1:0]    NUM_PAIRS   = 3'd7;
    localparam logic [3:0]          HDR_MONO    = 4'd7;
    localparam logic [3:0]          HDR_STEREO  = 4'd14;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ALIGN  = 1'b1;

    typedef enum logic [1:0] {
        CMD_INDEX,
        CMD_LOW,
        CMD_HIGH,
        CMD_DECODE
    } cmd_kind_t;

    typedef enum logic [1:0] {
        FLD_DELTA,
        FLD_SAMPLE1,
        FLD_SAMPLE2
    } hdr_field_t;

    typedef struct packed {
        cmd_kind_t  kind;
        hdr_field_t field;
        logic       chan;
        logic       last;
        logic       stereo;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_stream;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       last_of_item;
    } frame_t;

    function automatic logic [9:0] adapt_factor(input logic [3:0] code);
        logic [9:0] f;
        unique case (code)
            4'd4:    f = 10'd307;
            4'd5:    f = 10'd409;
            4'd6:    f = 10'd512;
            4'd7:    f = 10'd614;
            4'd8:    f = 10'd768;
            4'd9:    f = 10'd614;
            4'd10:   f = 10'd512;
            4'd11:   f = 10'd409;
            4'd12:   f = 10'd307;
            default: f = 10'd230;
        endcase
        return f;
    endfunction

    function automatic logic signed [10:0] coef_one(input logic [IDX_W-1:0] idx);
        logic signed [10:0] c;
        unique case (idx)
            3'd1:    c = 11'sd512;
            3'd2:    c = 11'sd0;
            3'd3:    c = 11'sd192;
            3'd4:    c = 11'sd240;
            3'd5:    c = 11'sd460;
            3'd6:    c = 11'sd392;
            default: c = 11'sd256;
        endcase
        return c;
    endfunction

    function automatic logic signed [10:0] coef_two(input logic [IDX_W-1:0] idx);
        logic signed [10:0] c;
        unique case (idx)
            3'd1:    c = -11'sd256;
            3'd3:    c = 11'sd64;
            3'd5:    c = -11'sd208;
            3'd6:    c = -11'sd232;
            default: c = 11'sd0;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/ms_adpcm_block_decoder_top.sv
// ----------------------------------------------------------------------------
// ms_adpcm_block_decoder_top - Microsoft ADPCM block decoder
// Decodes the data chunk byte by byte into 16-bit mono or stereo frames.
//
//   channel  | signals                              | word
//   ---------+--------------------------------------+-----------------------
//   bytes    | byte_valid, byte_ready, byte_data    | in_word_t, one byte
//   frames   | frame_valid, frame_ready, frame_data | frame_t, one frame
//   config   | cfg_we, cfg_index, cfg_data          | register write, no wait
//
// Stereo data byte: two predictor steps share one multiply stage.
// Mono data byte: each step waits on the previous one's state update.
// Header byte: taken once the predictor drains; the last emits two frames.
// Reset clears channel state to zero, deltas to 16; no clearing pass.
// Two-word queues on both sides let intake and output stall independently.
// ----------------------------------------------------------------------------
module ms_adpcm_block_decoder_top
    import msadpcm_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = 8192
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  in_word_t             byte_data,
    output logic                 frame_valid,
    input  logic                 frame_ready,
    output frame_t               frame_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALIGN_W-1:0]   cfg_data
);

    logic [CHAN_W-1:0]  num_channels_reg, num_channels_next;
    logic [ALIGN_W-1:0] block_align_reg, block_align_next;

    logic   cmd_push, cmd_pop, cmd_full, cmd_empty;
    cmd_t   cmd_in, cmd_out;
    logic   out_push, out_full, out_empty;
    frame_t out_in, out_out;

    always_comb
    begin
        num_channels_next = num_channels_reg;
        block_align_next  = block_align_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_CHANNELS: num_channels_next = cfg_data[CHAN_W-1:0];
                REG_BLOCK_ALIGN:  block_align_next  = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= CHAN_RESET;
            block_align_reg  <= ALIGN_RESET;
        end
        else
        begin
            num_channels_reg <= num_channels_next;
            block_align_reg  <= block_align_next;
        end
    end

    msadpcm_front #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .num_channels (num_channels_reg),
        .block_align  (block_align_reg),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd_word     (cmd_in)
    );

    msadpcm_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    msadpcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_word  (cmd_out),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_word  (out_in)
    );

    msadpcm_fifo #(
        .WIDTH ($bits(frame_t)),
        .DEPTH (2)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_in),
        .full      (out_full),
        .pop       (frame_valid && frame_ready),
        .pop_data  (out_out),
        .empty     (out_empty)
    );

    assign frame_valid = !out_empty;
    assign frame_data  = out_out;

endmodule

>>> hw/rtl/msadpcm_fifo.sv
// ----------------------------------------------------------------------------
// msadpcm_fifo - small register queue
// Decouples the byte front from the predictor back, and buffers output frames.
// ----------------------------------------------------------------------------
module msadpcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule

>>> hw/rtl/msadpcm_front.sv
// ----------------------------------------------------------------------------
// msadpcm_front - byte intake and block position tracking
// Classifies each byte as header field or data and queues a command word.
// ----------------------------------------------------------------------------
module msadpcm_front
    import msadpcm_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = 8192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  in_word_t           byte_data,
    input  logic [CHAN_W-1:0]  num_channels,
    input  logic [ALIGN_W-1:0] block_align,
    input  logic               cmd_full,
    output logic               cmd_push,
    output cmd_t               cmd_word
);

    localparam int POS_W = $clog2(MAX_BLOCK_BYTES);
    localparam int LEN_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CMP_W = (LEN_W > ALIGN_W) ? LEN_W : ALIGN_W;

    logic [POS_W-1:0] pos_reg, pos_next, pos_cur;
    logic [CMP_W-1:0] align_x, cap_x, clip_x;
    logic [LEN_W-1:0] len_w, pos_x, inc_x, hdr_x;
    logic [3:0]       hdr_len, nc, k;
    logic             stereo;

    assign stereo   = num_channels[1];
    assign hdr_len  = stereo ? HDR_STEREO : HDR_MONO;
    assign nc       = stereo ? 4'd2 : 4'd1;
    assign hdr_x    = LEN_W'(hdr_len);

    // clip the block length into [header, max]
    assign align_x  = CMP_W'(block_align);
    assign cap_x    = CMP_W'(MAX_BLOCK_BYTES);
    assign clip_x   = (align_x > cap_x) ? cap_x : align_x;
    assign len_w    = (LEN_W'(clip_x) < hdr_x) ? hdr_x : LEN_W'(clip_x);

    assign pos_cur  = (byte_data.start_of_stream || LEN_W'(pos_reg) >= len_w) ? '0 : pos_reg;
    assign pos_x    = LEN_W'(pos_cur);
    assign inc_x    = pos_x + 1'b1;
    assign k        = pos_cur[3:0] - nc;

    assign byte_ready = !cmd_full;
    assign cmd_push   = byte_valid && !cmd_full;

    always_comb
    begin
        cmd_word.kind      = CMD_DECODE;
        cmd_word.field     = FLD_DELTA;
        cmd_word.chan      = 1'b0;
        cmd_word.last      = 1'b0;
        cmd_word.stereo    = stereo;
        cmd_word.data_byte = byte_data.data_byte;
        priority if (pos_x < LEN_W'(nc))
        begin
            cmd_word.kind = CMD_INDEX;
            cmd_word.chan = stereo & pos_cur[0];
        end
        else if (pos_x < hdr_x)
        begin
            cmd_word.kind  = k[0] ? CMD_HIGH : CMD_LOW;
            cmd_word.field = hdr_field_t'(stereo ? k[3:2] : k[2:1]);
            cmd_word.chan  = stereo & k[1];
            cmd_word.last  = (pos_x == hdr_x - 1'b1);
        end
        else
        begin
            cmd_word.kind = CMD_DECODE;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd_push)
        begin
            pos_next = (inc_x >= len_w) ? '0 : POS_W'(inc_x);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

>>> hw/rtl/msadpcm_back.sv
// ----------------------------------------------------------------------------
// msadpcm_back - channel state and two-stage predictor
// Applies header fields, runs predictor steps and forms output frames.
// ----------------------------------------------------------------------------
module msadpcm_back
    import msadpcm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_empty,
    input  cmd_t   cmd_word,
    output logic   cmd_pop,
    input  logic   out_full,
    output logic   out_push,
    output frame_t out_word
);

    typedef enum logic [2:0] {
        ST_RUN       = 3'b001,
        ST_EMIT_OLD  = 3'b010,
        ST_EMIT_PREV = 3'b100
    } back_state_t;

    back_state_t st_reg, st_next;
    logic        phase_reg, phase_next;

    logic [IDX_W-1:0]           pred_idx_reg [2], pred_idx_next [2];
    logic [DELTA_W-1:0]         delta_reg    [2], delta_next    [2];
    logic signed [SAMPLE_W-1:0] prev_reg     [2], prev_next     [2];
    logic signed [SAMPLE_W-1:0] older_reg    [2], older_next    [2];
    logic [7:0]                 pending_reg, pending_next;
    logic signed [SAMPLE_W-1:0] left_hold_reg, left_hold_next;

    // multiply stage to clamp stage
    logic               b_valid_reg, b_valid_next;
    logic               b_ch_reg, b_ch_next;
    logic               b_emit_reg, b_emit_next;
    logic               b_last_reg, b_last_next;
    logic               b_pair_reg, b_pair_next;
    logic signed [26:0] m1_reg, m1_next;
    logic signed [26:0] m2_reg, m2_next;
    logic signed [20:0] md_reg, md_next;
    logic [25:0]        ma_reg, ma_next;

    logic                       head_valid, b_fire, b_free, hazard, issue, step_ch;
    logic [3:0]                 code;
    logic signed [3:0]          code_s;
    logic [IDX_W-1:0]           step_idx;
    logic [DELTA_W-1:0]         step_d;
    logic [15:0]                hdr_word;
    logic signed [27:0]         sum_w, sum_adj, quo_w;
    logic signed [21:0]         p_w;
    logic signed [SAMPLE_W-1:0] p_sat;
    logic [17:0]                nd_raw;
    logic [DELTA_W-1:0]         nd_sat;

    assign head_valid = !cmd_empty;
    assign b_fire     = b_valid_reg && (!b_emit_reg || !out_full);
    assign b_free     = !b_valid_reg || b_fire;
    assign step_ch    = cmd_word.stereo & phase_reg;
    assign code       = phase_reg ? cmd_word.data_byte[3:0] : cmd_word.data_byte[7:4];
    assign code_s     = code;
    assign hazard     = b_valid_reg && (b_ch_reg == step_ch);
    assign hdr_word   = {cmd_word.data_byte, pending_reg};
    assign step_idx   = pred_idx_reg[step_ch];
    assign step_d     = delta_reg[step_ch];

    // clamp stage: divide by 256 toward zero, add code*delta, saturate
    assign sum_w   = 28'(m1_reg) + 28'(m2_reg);
    assign sum_adj = sum_w + (sum_w[27] ? 28'sd255 : 28'sd0);
    assign quo_w   = sum_adj >>> 8;
    assign p_w     = 22'(quo_w) + 22'(md_reg);
    assign p_sat   = (p_w < 22'(SAMPLE_MIN)) ? SAMPLE_MIN :
                     (p_w > 22'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_W'(p_w);
    assign nd_raw  = ma_reg[25:8];
    assign nd_sat  = (nd_raw < 18'(DELTA_FLOOR)) ? DELTA_FLOOR :
                     (|nd_raw[17:16]) ? '1 : nd_raw[15:0];

    always_comb
    begin
        st_next        = st_reg;
        phase_next     = phase_reg;
        pred_idx_next  = pred_idx_reg;
        delta_next     = delta_reg;
        prev_next      = prev_reg;
        older_next     = older_reg;
        pending_next   = pending_reg;
        left_hold_next = left_hold_reg;
        cmd_pop        = 1'b0;
        out_push       = 1'b0;
        out_word       = '0;
        issue          = 1'b0;

        if (b_fire)
        begin
            older_next[b_ch_reg] = prev_reg[b_ch_reg];
            prev_next[b_ch_reg]  = p_sat;
            delta_next[b_ch_reg] = nd_sat;
            if (b_emit_reg)
            begin
                out_push              = 1'b1;
                out_word.left_sample  = b_pair_reg ? left_hold_reg : p_sat;
                out_word.right_sample = p_sat;
                out_word.last_of_item = b_last_reg;
            end
            else
            begin
                left_hold_next = p_sat;
            end
        end

        unique case (st_reg)
            ST_RUN:
            begin
                if (head_valid)
                begin
                    unique case (cmd_word.kind)
                        CMD_DECODE:
                        begin
                            if (b_free && !hazard)
                            begin
                                issue      = 1'b1;
                                phase_next = !phase_reg;
                                cmd_pop    = phase_reg;
                            end
                        end
                        CMD_INDEX:
                        begin
                            // header writes wait for the predictor to drain
                            if (!b_valid_reg)
                            begin
                                pred_idx_next[cmd_word.chan] =
                                    (cmd_word.data_byte < 8'(NUM_PAIRS)) ?
                                    cmd_word.data_byte[IDX_W-1:0] : '0;
                                cmd_pop = 1'b1;
                            end
                        end
                        CMD_LOW:
                        begin
                            if (!b_valid_reg)
                            begin
                                pending_next = cmd_word.data_byte;
                                cmd_pop      = 1'b1;
                            end
                        end
                        CMD_HIGH:
                        begin
                            if (!b_valid_reg)
                            begin
                                unique case (cmd_word.field)
                                    FLD_DELTA:   delta_next[cmd_word.chan] = hdr_word;
                                    FLD_SAMPLE1: prev_next[cmd_word.chan]  = hdr_word;
                                    FLD_SAMPLE2: older_next[cmd_word.chan] = hdr_word;
                                    default:     ;
                                endcase
                                if (cmd_word.last)
                                begin
                                    st_next = ST_EMIT_OLD;
                                end
                                else
                                begin
                                    cmd_pop = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EMIT_OLD:
            begin
                if (!out_full)
                begin
                    out_push              = 1'b1;
                    out_word.left_sample  = older_reg[0];
                    out_word.right_sample = cmd_word.stereo ? older_reg[1] : older_reg[0];
                    out_word.last_of_item = 1'b0;
                    st_next               = ST_EMIT_PREV;
                end
            end
            ST_EMIT_PREV:
            begin
                if (!out_full)
                begin
                    out_push              = 1'b1;
                    out_word.left_sample  = prev_reg[0];
                    out_word.right_sample = cmd_word.stereo ? prev_reg[1] : prev_reg[0];
                    out_word.last_of_item = 1'b1;
                    cmd_pop               = 1'b1;
                    st_next               = ST_RUN;
                end
            end
            default:
            begin
                st_next = ST_RUN;
            end
        endcase
    end

    // multiply stage
    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_ch_next    = b_ch_reg;
        b_emit_next  = b_emit_reg;
        b_last_next  = b_last_reg;
        b_pair_next  = b_pair_reg;
        m1_next      = m1_reg;
        m2_next      = m2_reg;
        md_next      = md_reg;
        ma_next      = ma_reg;
        if (b_free)
        begin
            b_valid_next = issue;
        end
        if (issue)
        begin
            b_ch_next   = step_ch;
            // stereo left step holds its sample for the right step
            b_emit_next = !(cmd_word.stereo && !phase_reg);
            b_last_next = phase_reg;
            b_pair_next = cmd_word.stereo;
            m1_next     = 27'(prev_reg[step_ch]) * 27'(coef_one(step_idx));
            m2_next     = 27'(older_reg[step_ch]) * 27'(coef_two(step_idx));
            md_next     = 21'(code_s) * $signed({5'b0, step_d});
            ma_next     = 26'(adapt_factor(code)) * 26'(step_d);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_RUN;
            phase_reg     <= 1'b0;
            pred_idx_reg  <= '{default: '0};
            delta_reg     <= '{default: DELTA_RESET};
            prev_reg      <= '{default: '0};
            older_reg     <= '{default: '0};
            pending_reg   <= '0;
            left_hold_reg <= '0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            pred_idx_reg  <= pred_idx_next;
            delta_reg     <= delta_next;
            prev_reg      <= prev_next;
            older_reg     <= older_next;
            pending_reg   <= pending_next;
            left_hold_reg <= left_hold_next;
            b_valid_reg   <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_ch_reg   <= b_ch_next;
        b_emit_reg <= b_emit_next;
        b_last_reg <= b_last_next;
        b_pair_reg <= b_pair_next;
        m1_reg     <= m1_next;
        m2_reg     <= m2_next;
        md_reg     <= md_next;
        ma_reg     <= ma_next;
    end

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_RUN) |-> !b_valid_reg)
        else $error("header frames emitted with a predictor step in flight");

    a_no_same_chan_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && issue) |-> (b_ch_reg != step_ch))
        else $error("predictor step issued on a channel still being updated");

endmodule

>>> tb/ms_adpcm_block_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// ms_adpcm_block_decoder_top_tb - self-checking bench for the MS ADPCM decoder
// Streams block-structured byte sequences (headers plus nibble data, with some
// noise) through the byte channel under several channel and block settings.
// A local decoder model predicts every frame, and the monitor checks each
// frame in order against it. Both channels idle at random outside steady runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ms_adpcm_block_decoder_top_tb;
    import msadpcm_pkg::*;

    localparam int MAX_BLOCK = 8192;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 byte_valid = 1'b0;
    logic                 byte_ready;
    in_word_t             byte_data = '0;
    logic                 frame_valid;
    logic                 frame_ready = 1'b0;
    frame_t               frame_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ALIGN_W-1:0]   cfg_data = '0;

    ms_adpcm_block_decoder_top #(
        .MAX_BLOCK_BYTES(MAX_BLOCK)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_data   (byte_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // decoder tables
    int adapt_gain [16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                            768, 614, 512, 409, 307, 230, 230, 230};
    int tap_one [7] = '{256, 512, 0, 192, 240, 460, 392};
    int tap_two [7] = '{0, -256, 0, 64, 0, -208, -232};

    // local copy of registers and channel state
    logic [CHAN_W-1:0]  chan_setting = CHAN_RESET;
    logic [ALIGN_W-1:0] align_setting = ALIGN_RESET;
    int                 blk_pos = 0;
    logic [2:0]         pair_sel [2] = '{3'd0, 3'd0};
    logic [15:0]        step_size [2] = '{16'd16, 16'd16};
    logic [15:0]        last_s [2] = '{16'd0, 16'd0};
    logic [15:0]        prior_s [2] = '{16'd0, 16'd0};
    logic [7:0]         low_byte = 8'd0;

    in_word_t pending_bytes [$];
    frame_t   expected_frames [$];
    int       bytes_sent = 0;
    int       bytes_taken = 0;
    int       frames_seen = 0;
    int       errors = 0;
    int       settings_run = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    bit       steady = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d words still expected", expected_frames.size());
        $display("** ms_adpcm_block_decoder_top: FAILED **");
        $finish;
    end

    function automatic int block_len();
        int len;
        len = align_setting;
        if (len > MAX_BLOCK) len = MAX_BLOCK;
        if (len < 7 * ((chan_setting >= 2) ? 2 : 1)) len = 7 * ((chan_setting >= 2) ? 2 : 1);
        return len;
    endfunction

    function automatic logic [15:0] predict_sample(int ch, logic [3:0] code);
        int pair;
        int s1;
        int s2;
        int sc;
        int d;
        int p;
        int nd;
        pair = (pair_sel[ch] < 7) ? pair_sel[ch] : 0;
        s1 = $signed(last_s[ch]);
        s2 = $signed(prior_s[ch]);
        sc = $signed(code);
        d = step_size[ch];
        p = (s1 * tap_one[pair] + s2 * tap_two[pair]) / 256 + sc * d;
        if (p < -32768) p = -32768;
        if (p > 32767) p = 32767;
        prior_s[ch] = last_s[ch];
        last_s[ch] = p[15:0];
        nd = adapt_gain[code] * d / 256;
        if (nd < 16) nd = 16;
        if (nd > 65535) nd = 65535;
        step_size[ch] = nd[15:0];
        return p[15:0];
    endfunction

    function automatic void push_frame(logic [15:0] l, logic [15:0] r, logic last);
        frame_t f;
        f.left_sample = l;
        f.right_sample = r;
        f.last_of_item = last;
        expected_frames.insert(expected_frames.size(), f);
    endfunction

    function automatic void decode_byte(in_word_t w);
        bit          stereo;
        int          nc;
        int          hdr;
        int          len;
        int          pos;
        int          k;
        int          fld;
        int          rem;
        int          ch;
        logic [15:0] v;
        logic [15:0] a;
        logic [15:0] c;
        stereo = chan_setting >= 2;
        nc = stereo ? 2 : 1;
        hdr = 7 * nc;
        len = block_len();
        if (w.start_of_stream) blk_pos = 0;
        if (blk_pos >= len) blk_pos = 0;
        pos = blk_pos;
        if (pos < nc)
        begin
            pair_sel[pos] = (w.data_byte < 7) ? w.data_byte[2:0] : 3'd0;
        end
        else if (pos < hdr)
        begin
            k = pos - nc;
            fld = k / (2 * nc);
            rem = k % (2 * nc);
            ch = (rem / 2) & 1;
            if (rem % 2 == 0)
            begin
                low_byte = w.data_byte;
            end
            else
            begin
                v = {w.data_byte, low_byte};
                if (fld == 0) step_size[ch] = v;
                else if (fld == 1) last_s[ch] = v;
                else prior_s[ch] = v;
            end
            // last header byte releases sample2 then sample1
            if (pos == hdr - 1)
            begin
                push_frame(prior_s[0], prior_s[stereo ? 1 : 0], 1'b0);
                push_frame(last_s[0], last_s[stereo ? 1 : 0], 1'b1);
            end
        end
        else if (stereo)
        begin
            a = predict_sample(0, w.data_byte[7:4]);
            c = predict_sample(1, w.data_byte[3:0]);
            push_frame(a, c, 1'b1);
        end
        else
        begin
            a = predict_sample(0, w.data_byte[7:4]);
            push_frame(a, a, 1'b0);
            c = predict_sample(0, w.data_byte[3:0]);
            push_frame(c, c, 1'b1);
        end
        blk_pos = pos + 1;
        if (blk_pos >= len) blk_pos = 0;
    endfunction

    // byte driver: accept at the rising edge, present the next word at the falling one
    always @(posedge clk)
    begin
        if (rst_n && byte_valid && byte_ready)
        begin
            decode_byte(byte_data);
            bytes_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(byte_valid && bytes_sent != bytes_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                byte_valid <= 1'b0;
            end
            else if (pending_bytes.size() == 0)
            begin
                byte_valid <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 6);
                byte_valid <= 1'b0;
            end
            else
            begin
                byte_data <= pending_bytes.pop_front();
                byte_valid <= 1'b1;
                bytes_sent++;
            end
        end
    end

    // frame monitor
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                frame_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                frame_ready <= 1'b0;
            end
            else
            begin
                frame_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && frame_valid && frame_ready)
        begin
            frames_seen++;
            if (expected_frames.size() == 0)
            begin
                errors++;
                $display("%0t: expected no word, got L=%0d R=%0d last=%0b", $time,
                         frame_data.left_sample, frame_data.right_sample,
                         frame_data.last_of_item);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (frame_data.left_sample !== want.left_sample
                        || frame_data.right_sample !== want.right_sample
                        || frame_data.last_of_item !== want.last_of_item)
                begin
                    errors++;
                    $display("%0t: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                             $time, want.left_sample, want.right_sample,
                             want.last_of_item, frame_data.left_sample,
                             frame_data.right_sample, frame_data.last_of_item);
                end
            end
        end
    end

    task automatic push_byte(logic [7:0] b, logic sos);
        in_word_t w;
        w.data_byte = b;
        w.start_of_stream = sos;
        pending_bytes.insert(pending_bytes.size(), w);
    endtask

    function automatic logic [15:0] rand_sample();
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 8191) - 4096);
    endfunction

    task automatic push_header(logic sos, int nc);
        logic [15:0] v;
        int          r;
        for (int ch = 0; ch < nc; ch++)
        begin
            r = $urandom_range(0, 9);
            if (r >= 7) r = $urandom_range(7, 255);
            push_byte(8'(r), (ch == 0) ? sos : 1'b0);
        end
        for (int ch = 0; ch < nc; ch++)
        begin
            r = $urandom_range(0, 15);
            if (r == 0) v = 16'd0;
            else if (r < 3) v = 16'($urandom_range(0, 65535));
            else v = 16'($urandom_range(16, 2048));
            push_byte(v[7:0], 1'b0);
            push_byte(v[15:8], 1'b0);
        end
        for (int i = 0; i < 2 * nc; i++)
        begin
            v = rand_sample();
            push_byte(v[7:0], 1'b0);
            push_byte(v[15:8], 1'b0);
        end
    endtask

    // drain everything, then let the decoder sit idle before new settings
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || bytes_sent != bytes_taken
                || expected_frames.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ALIGN_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_NUM_CHANNELS) chan_setting = value[CHAN_W-1:0];
        else align_setting = value;
    endtask

    task automatic run_phase(logic [1:0] chans, logic [ALIGN_W-1:0] align, int count,
                             bit quiet);
        int nc;
        int hdr;
        int room;
        int ndata;
        int made;
        int n;
        bit prev_full;
        logic sos;
        wait_idle();
        write_reg(REG_NUM_CHANNELS, ALIGN_W'(chans));
        write_reg(REG_BLOCK_ALIGN, align);
        settings_run++;
        steady = quiet;
        nc = (chans >= 2) ? 2 : 1;
        hdr = 7 * nc;
        room = block_len() - hdr;
        made = 0;
        // the first block may lean on the old position, which can lie past the new length
        prev_full = 1'b1;
        while (made < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                made += n;
                prev_full = 1'b0;
            end
            else
            begin
                sos = prev_full ? 1'($urandom_range(0, 1)) : 1'b1;
                push_header(sos, nc);
                if (room <= 48 && $urandom_range(0, 2) != 0) ndata = room;
                else ndata = $urandom_range(0, (room < 48) ? room : 48);
                for (int i = 0; i < ndata; i++)
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
                made += hdr + ndata;
                prev_full = (ndata == room);
            end
        end
    endtask

    initial
    begin
        logic [7:0] directed [$];
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // mono at reset settings: out-of-range index, full-scale delta and samples,
        // clamping both ways, delta ceiling; then a restart mid-block with zero delta
        directed = '{8'd9, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80,
                     8'h77, 8'h88, 8'h08, 8'hF0};
        foreach (directed[i]) push_byte(directed[i], i == 0);
        directed = '{8'd6, 8'h00, 8'h00, 8'h34, 8'h12, 8'hDC, 8'hFE,
                     8'h00, 8'h12, 8'hC4, 8'h9B, 8'h5A};
        foreach (directed[i]) push_byte(directed[i], i == 0);

        run_phase(2'd1, 14'd16, 250, 1'b0);
        run_phase(2'd2, 14'd32, 250, 1'b0);
        run_phase(2'd0, 14'd8192, 200, 1'b0);
        run_phase(2'd3, 14'd16, 200, 1'b0);
        run_phase(2'd2, 14'd0, 150, 1'b0);
        run_phase(2'd1, 14'd5, 100, 1'b0);
        run_phase(2'd2, 14'd16383, 200, 1'b0);
        run_phase(2'd1, 14'd100, 250, 1'b0);
        run_phase(2'd2, 14'd200, 300, 1'b1);
        wait_idle();

        $display("Decoded %0d bytes into %0d frames over %0d register settings:", bytes_taken,
                 frames_seen, settings_run);
        $display("mono and stereo, short, header-only and oversize blocks, restarts and noise.");
        if (errors == 0)
        begin
            $display("** ms_adpcm_block_decoder_top: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("** ms_adpcm_block_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> ms_adpcm_block_decoder_top.f
hw/rtl/msadpcm_pkg.sv
hw/rtl/msadpcm_fifo.sv
hw/rtl/msadpcm_front.sv
hw/rtl/msadpcm_back.sv
hw/rtl/ms_adpcm_block_decoder_top.sv
tb/ms_adpcm_block_decoder_top_tb.sv
